FILE: design/mtp_pkg.sv
// mtp_pkg: shared types, constants and word functions of the mt19937 generator
// no dependencies
`default_nettype none

package mtp_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned IDX_W       = 10;

  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] TWIST_OFS  = IDX_W'(397);
  localparam logic [IDX_W-1:0] FAR_SPLIT  = IDX_W'(STATE_WORDS - 397);

  localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h80000000;
  localparam logic [31:0] LOW_BITS     = 32'h7fffffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] SEED_DEFAULT = 32'd5489;

  localparam logic [8:0] MAX_BYTES = 9'd256;

  localparam logic [1:0] ADDR_SEED = 2'd0;

  typedef struct packed {
    logic [6:0] words;
    logic [2:0] last_bytes;
  } cmd_t;

  function automatic logic [31:0] temper(input logic [31:0] y);
    logic [31:0] t;
    t = y ^ (y >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] far);
    logic [31:0] y;
    y = (a & HIGH_BIT) | (b & LOW_BITS);
    return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
  endfunction

endpackage

`default_nettype wire

FILE: design/mtp_front.sv
// mtp_front: accepts byte requests, saturates them and turns them into word commands
// depends on mtp_pkg
`default_nettype none

module mtp_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [8:0]    in_byte_count,
  input  wire logic          busy,
  output logic               push_valid,
  input  wire logic          push_ready,
  output mtp_pkg::cmd_t      push_data
);

  logic [8:0] sat;
  logic [8:0] sat_m1;
  logic [8:0] sat_p3;

  always_comb begin
    sat    = (in_byte_count > mtp_pkg::MAX_BYTES) ? mtp_pkg::MAX_BYTES : in_byte_count;
    sat_m1 = sat - 9'd1;
    sat_p3 = sat + 9'd3;
    push_data.words      = 7'(sat_p3 >> 2);
    push_data.last_bytes = {1'b0, sat_m1[1:0]} + 3'd1;
  end

  // zero-byte transactions are taken and dropped here
  assign in_ready   = push_ready & ~busy;
  assign push_valid = in_valid & ~busy & (in_byte_count != 9'd0);

endmodule

`default_nettype wire

FILE: design/mtp_queue.sv
// mtp_queue: small command queue between request front and word generator
// depends on mtp_pkg
`default_nettype none

module mtp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire mtp_pkg::cmd_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output mtp_pkg::cmd_t      pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mtp_pkg::cmd_t   mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/mtp_back.sv
// mtp_back: state memory, seeding pass, incremental twist, tempering and result register
// depends on mtp_pkg
`default_nettype none

module mtp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          seed_start,
  input  wire logic [31:0]   seed_value,
  output logic               busy,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire mtp_pkg::cmd_t cmd_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        out_random_word,
  output logic [2:0]         out_valid_bytes,
  output logic               out_last_word
);

  localparam int unsigned IW = mtp_pkg::IDX_W;

  logic [31:0] mem_r [mtp_pkg::STATE_WORDS];

  // seeding pass
  logic          seeding_r, seeding_nxt;
  logic [IW-1:0] seed_k_r, seed_k_nxt;
  logic [31:0]   seed_p_r;
  logic [31:0]   seed_x;
  logic [31:0]   seed_prod;
  logic [31:0]   seed_wdata;

  // issue side
  logic          active_r, active_nxt;
  logic [6:0]    rem_r, rem_nxt;
  logic [2:0]    lastb_r, lastb_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] next_addr, far_addr;
  logic          issue, take;

  // twist stage
  logic          b_vld_r, b_vld_nxt;
  logic [IW-1:0] b_k_r;
  logic [2:0]    b_bytes_r;
  logic          b_last_r;
  logic [31:0]   rd_next_r, rd_far_r;
  logic [31:0]   carry_r;
  logic [31:0]   twisted;
  logic          b_adv;

  logic          out_vld_r, out_vld_nxt;
  logic [31:0]   out_word_r;
  logic [2:0]    out_bytes_r;
  logic          out_last_r;

  assign seed_x     = seed_p_r ^ (seed_p_r >> 30);
  assign seed_prod  = mtp_pkg::SEED_MULT * seed_x;
  assign seed_wdata = (seed_k_r == '0) ? seed_value : seed_prod + 32'(seed_k_r);

  assign b_adv   = b_vld_r & (~out_vld_r | out_ready);
  assign issue   = active_r & ~seeding_r & (~b_vld_r | b_adv);
  assign take    = cmd_valid & cmd_ready;
  assign twisted = mtp_pkg::mix(carry_r, rd_next_r, rd_far_r);

  assign next_addr = (k_r == mtp_pkg::IDX_LAST) ? '0 : k_r + 1'b1;
  assign far_addr  = (k_r < mtp_pkg::FAR_SPLIT) ? k_r + mtp_pkg::TWIST_OFS
                                                : k_r - mtp_pkg::FAR_SPLIT;

  assign cmd_ready = ~seeding_r & (~active_r | (issue & (rem_r == 7'd1)));
  assign busy      = seeding_r;

  always_comb begin
    seeding_nxt = seeding_r;
    seed_k_nxt  = seed_k_r;
    if (seed_start) begin
      seeding_nxt = 1'b1;
      seed_k_nxt  = '0;
    end else if (seeding_r) begin
      seed_k_nxt = seed_k_r + 1'b1;
      if (seed_k_r == mtp_pkg::IDX_LAST) begin
        seeding_nxt = 1'b0;
      end
    end

    active_nxt = active_r;
    rem_nxt    = rem_r;
    lastb_nxt  = lastb_r;
    k_nxt      = k_r;
    if (issue) begin
      rem_nxt = rem_r - 7'd1;
      k_nxt   = next_addr;
      if (rem_r == 7'd1) begin
        active_nxt = 1'b0;
      end
    end
    if (take) begin
      active_nxt = 1'b1;
      rem_nxt    = cmd_data.words;
      lastb_nxt  = cmd_data.last_bytes;
    end
    if (seeding_r && seed_k_r == '0) begin
      k_nxt = '0;
    end

    b_vld_nxt = issue ? 1'b1 : (b_adv ? 1'b0 : b_vld_r);
    out_vld_nxt = b_adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeding_r <= 1'b1;
      seed_k_r  <= '0;
      active_r  <= 1'b0;
      rem_r     <= '0;
      k_r       <= '0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      seeding_r <= seeding_nxt;
      seed_k_r  <= seed_k_nxt;
      active_r  <= active_nxt;
      rem_r     <= rem_nxt;
      k_r       <= k_nxt;
      b_vld_r   <= b_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lastb_r <= lastb_nxt;
    if (seeding_r) begin
      seed_p_r <= seed_wdata;
      if (seed_k_r == '0) begin
        carry_r <= seed_value;
      end
    end else if (b_adv) begin
      carry_r <= rd_next_r;
    end
    if (issue) begin
      b_k_r     <= k_r;
      b_bytes_r <= (rem_r == 7'd1) ? lastb_r : 3'd4;
      b_last_r  <= (rem_r == 7'd1);
    end
    if (b_adv) begin
      out_word_r  <= mtp_pkg::temper(twisted);
      out_bytes_r <= b_bytes_r;
      out_last_r  <= b_last_r;
    end
  end

  // state memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (seeding_r) begin
      mem_r[seed_k_r] <= seed_wdata;
    end else if (b_adv) begin
      mem_r[b_k_r] <= twisted;
    end
    if (issue) begin
      rd_next_r <= mem_r[next_addr];
      rd_far_r  <= mem_r[far_addr];
    end
  end

  assign out_valid       = out_vld_r;
  assign out_random_word = out_word_r;
  assign out_valid_bytes = out_bytes_r;
  assign out_last_word   = out_last_r;

endmodule

`default_nettype wire

FILE: design/mersenne_twister_prng.sv
// mersenne_twister_prng: mt19937 random byte source, top level
// depends on mtp_pkg, mtp_front, mtp_queue, mtp_back
//
// input channel: in_valid/in_ready with in_byte_count, the bytes wanted (1..256,
// larger values give 256, zero is taken and gives nothing).
// result channel: out_valid/out_ready with one 32-bit tempered word per transaction,
// out_valid_bytes low bytes of it belong to the request, out_last_word on the final one.
// configuration: apb-style port, seed register at address 0 (reset value 5489).
// path: a request passes the command queue, issue side, twist stage and result register.
// throughput: one word per cycle while the receiver is ready, ceil(bytes/4) words
// per request, up to 64; the state is twisted one word at a time as words are drawn,
// two memory reads and one write each. reset and every seed write run a seeding pass
// over the state memory, one word per cycle through the seed multiplier, while in_ready
// stays low. a stalled receiver holds the result register; the twist stage and the
// command queue fill behind it and in_ready falls once the queue is full.
`default_nettype none

module mersenne_twister_prng #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [8:0]  in_byte_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_random_word,
  output logic [2:0]       out_valid_bytes,
  output logic             out_last_word,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic          seed_wr;
  logic [31:0]   seed_r;
  logic          busy;
  logic          push_valid, push_ready;
  mtp_pkg::cmd_t push_data;
  logic          pop_valid, pop_ready;
  mtp_pkg::cmd_t pop_data;

  assign pready  = 1'b1;
  assign seed_wr = psel & penable & pwrite & (paddr == mtp_pkg::ADDR_SEED);
  assign prdata  = (paddr == mtp_pkg::ADDR_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= mtp_pkg::SEED_DEFAULT;
    end else if (seed_wr) begin
      seed_r <= pwdata;
    end
  end

  mtp_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_count (in_byte_count),
    .busy          (busy),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  mtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mtp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .seed_start      (seed_wr),
    .seed_value      (seed_r),
    .busy            (busy),
    .cmd_valid       (pop_valid),
    .cmd_ready       (pop_ready),
    .cmd_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .out_valid_bytes (out_valid_bytes),
    .out_last_word   (out_last_word)
  );

endmodule

`default_nettype wire

FILE: test/tb.sv
// tb: self-checking testbench for the mt19937 random byte source mersenne_twister_prng
// depends on mtp_pkg and mersenne_twister_prng; predicts every word from its own state copy
// drives byte requests and seed writes, checks each result word in order

module tb;

  localparam int unsigned STATE_N     = 624;
  localparam int unsigned TWIST_SHIFT = 397;
  localparam logic [31:0] TWIST_XOR   = 32'h9908b0df;
  localparam logic [31:0] UPPER_MASK  = 32'h80000000;
  localparam logic [31:0] LOWER_MASK  = 32'h7fffffff;
  localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_MASK_C = 32'hefc60000;
  localparam logic [31:0] INIT_MULT   = 32'd1812433253;
  localparam logic [31:0] RESET_SEED  = 32'd5489;
  localparam int unsigned BYTE_CAP    = 256;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 73;

  typedef enum int {GAP_NONE, GAP_SPARSE, GAP_HEAVY} gap_style_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } word_rec_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [8:0]  in_byte_count;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_random_word;
  logic [2:0]  out_valid_bytes;
  logic        out_last_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] mt_state [STATE_N];
  int unsigned draw_idx;

  logic [8:0]  pending_counts [$];
  word_rec_t   expected_words [$];
  word_rec_t   due;
  gap_style_t  in_gap_style;
  gap_style_t  out_gap_style;
  int unsigned in_gap_left;
  int unsigned out_gap_left;
  int unsigned hold_left = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  mersenne_twister_prng uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_count   (in_byte_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .out_valid_bytes (out_valid_bytes),
    .out_last_word   (out_last_word),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void reseed_state(input logic [31:0] s);
    logic [31:0] p;
    mt_state[0] = s;
    for (int k = 1; k < STATE_N; k++) begin
      p = mt_state[k-1];
      mt_state[k] = INIT_MULT * (p ^ (p >> 30)) + 32'(k);
    end
    draw_idx = STATE_N;
  endfunction

  function automatic void twist_state();
    logic [31:0] y;
    for (int k = 0; k < STATE_N; k++) begin
      y = (mt_state[k] & UPPER_MASK) | (mt_state[(k + 1) % STATE_N] & LOWER_MASK);
      mt_state[k] = mt_state[(k + TWIST_SHIFT) % STATE_N] ^ (y >> 1)
                    ^ (y[0] ? TWIST_XOR : 32'd0);
    end
    draw_idx = 0;
  endfunction

  function automatic logic [31:0] tempered(input logic [31:0] y);
    logic [31:0] t;
    t = y ^ (y >> 11);
    t = t ^ ((t << 7) & TEMPER_MASK_B);
    t = t ^ ((t << 15) & TEMPER_MASK_C);
    return t ^ (t >> 18);
  endfunction

  // queue up the words that one request of cnt bytes produces
  function automatic void predict_words(input logic [8:0] cnt);
    int unsigned left;
    int unsigned take;
    word_rec_t   r;
    left = (cnt > BYTE_CAP) ? BYTE_CAP : cnt;
    while (left > 0) begin
      take = (left < 4) ? left : 4;
      if (draw_idx >= STATE_N) twist_state();
      r.word = tempered(mt_state[draw_idx]);
      draw_idx++;
      left -= take;
      r.nbytes = 3'(take);
      r.last = (left == 0);
      expected_words.push_back(r);
    end
  endfunction

  function automatic int unsigned draw_gap(input gap_style_t style);
    case (style)
      GAP_NONE:   return 0;
      GAP_SPARSE: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : 0;
      default:    return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [8:0] draw_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 9'd0;
    if (sel < 12) return 9'($urandom_range(257, 511));
    if (sel < 60) return 9'($urandom_range(1, 16));
    return 9'($urandom_range(1, BYTE_CAP));
  endfunction

  task automatic flag_error(input string what, input word_rec_t want);
    err_count++;
    if (err_count <= 10)
      $display("mismatch (%s): want word %h bytes %0d last %0d, got word %h bytes %0d last %0d",
               what, want.word, want.nbytes, want.last,
               out_random_word, out_valid_bytes, out_last_word);
  endtask

  task automatic write_seed(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= mtp_pkg::ADDR_SEED;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reseed_state(value);
  endtask

  // checked mid-cycle so that the driver and monitor updates of the edge have settled
  task automatic wait_drained(input int unsigned pause);
    while (pending_counts.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (pause) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_words(in_byte_count);
        in_gap_left = draw_gap(in_gap_style);
      end
      if (!in_valid || in_ready) begin
        if (in_gap_left != 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_counts.size() != 0) begin
          in_valid <= 1'b1;
          in_byte_count <= pending_counts.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          due = '{word: 32'd0, nbytes: 3'd0, last: 1'b0};
          flag_error("no word expected", due);
        end else begin
          due = expected_words.pop_front();
          if (out_random_word !== due.word || out_valid_bytes !== due.nbytes ||
              out_last_word !== due.last)
            flag_error("wrong word", due);
        end
        out_gap_left = draw_gap(out_gap_style);
      end else if (out_gap_left != 0) begin
        out_gap_left--;
      end
      out_ready <= (out_gap_left == 0) && (hold_left == 0);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [8:0]  directed [25];
    logic [31:0] seeds [PHASES];
    directed = '{9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd0, 9'd7, 9'd8, 9'd12, 9'd255, 9'd256,
                 9'd257, 9'd300, 9'd384, 9'd511, 9'd0, 9'd1, 9'd64, 9'd128, 9'd256,
                 9'd256, 9'd256, 9'd256, 9'd256, 9'd256};
    seeds = '{32'd0, 32'hffffffff, $urandom(), 32'd1, $urandom(), RESET_SEED};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte_count = 9'd0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = mtp_pkg::ADDR_SEED;
    pwdata = 32'd0;
    in_gap_style = GAP_SPARSE;
    out_gap_style = GAP_SPARSE;
    reseed_state(RESET_SEED);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // sizes at the edges, zero and oversize requests, a run across the twist point
    foreach (directed[i]) pending_counts.push_back(directed[i]);
    wait_drained(8);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_seed(seeds[ph]);
      in_gap_style = gap_style_t'(ph % 3);
      out_gap_style = gap_style_t'((ph + 1) % 3);
      if (ph == 2) begin
        in_gap_style = GAP_NONE;
        @(posedge clk);
        hold_left <= 1500;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) pending_counts.push_back(draw_count());
      wait_drained(8);
    end

    wait_drained(20);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
design/mtp_pkg.sv
design/mtp_front.sv
design/mtp_queue.sv
design/mtp_back.sv
design/mersenne_twister_prng.sv
test/tb.sv
